[rtl/core/pfa_pkg.sv]
package pfa_pkg;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;
  localparam logic [1:0] KIND_COAL  = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_TOTAL_SIZE = 1'b1;

  localparam logic [15:0] UNITS_MAX = 16'hFFFF;

  // One partition table entry as it sits in the memory word.
  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] used;
    logic [15:0] size;
    logic [15:0] start;
  } entry_t;

endpackage

[rtl/core/pfa_if.sv]
interface pfa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] owner_id;
  logic [15:0] request_size;
  modport source (output valid, kind, owner_id, request_size, input ready);
  modport sink   (input valid, kind, owner_id, request_size, output ready);
endinterface

interface pfa_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [3:0]  block_index;
  logic [15:0] block_start;
  logic [15:0] free_units;
  logic [4:0]  block_total;
  modport source (output valid, ok, block_index, block_start, free_units, block_total,
                  input ready);
  modport sink   (input valid, ok, block_index, block_start, free_units, block_total,
                  output ready);
endinterface

[rtl/core/partition_fit_allocator_core.sv]
// Flow: add_block and a rejected allocate go from S_IDLE straight to S_DONE; allocate,
// free and coalesce read the table in S_WALK (one entry per cycle, none if it is empty),
// pass S_FIN (the closing write for allocate and coalesce) and reach S_DONE, which
// registers the result once the output is free.
// Throughput: one request at a time; a new one can be taken in the cycle the result
// appears, unless an output stall holds S_DONE. Reset (synchronous, active low) empties
// the table and loads the free counter with 65535.
module partition_fit_allocator_core
  import pfa_pkg::*;
#(
  parameter int NUM_PARTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pfa_in_if.sink      in_ch,
  pfa_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CW = $clog2(NUM_PARTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN, S_DONE} state_t;

  // Configuration and table bookkeeping.
  logic [1:0]    fit_policy_r, fit_policy_nxt;
  logic [15:0]   total_size_r, total_size_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [16:0]   covered_r, covered_nxt;
  logic [15:0]   free_r, free_nxt;
  // The end of the last partition; the next added partition starts here.
  logic [15:0]   tail_r, tail_nxt;

  state_t        state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [15:0]   owner_r, owner_nxt;
  logic [15:0]   size_r, size_nxt;

  // Table walk: read pointer, returned-data index, and coalesce write pointer.
  logic [CW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic          rvalid_r, rvalid_nxt;
  logic [CW-1:0] didx_r, didx_nxt;
  logic [CW-1:0] wr_ptr_r, wr_ptr_nxt;
  entry_t        cur_r, cur_nxt;
  logic          have_cur_r, have_cur_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] pick_r, pick_nxt;
  entry_t        pick_e_r, pick_e_nxt;

  logic          res_ok_r, res_ok_nxt;
  logic [3:0]    res_idx_r, res_idx_nxt;
  logic [15:0]   res_start_r, res_start_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic [3:0]    out_idx_r, out_idx_nxt;
  logic [15:0]   out_start_r, out_start_nxt;
  logic [15:0]   out_free_r, out_free_nxt;
  logic [4:0]    out_total_r, out_total_nxt;

  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;
  logic          mem_we;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;

  logic          cfg_we;
  logic [31:0]   count32, pick32, wrp32;
  logic [16:0]   free_sum, merge_sum;
  entry_t        e;

  pfa_mem #(.DEPTH(NUM_PARTS), .AW(AW)) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_FIT_POLICY: prdata = {30'd0, fit_policy_r};
      REG_TOTAL_SIZE: prdata = {16'd0, total_size_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.block_index = out_idx_r;
  assign out_ch.block_start = out_start_r;
  assign out_ch.free_units  = out_free_r;
  assign out_ch.block_total = out_total_r;

  assign e         = mem_rd_data;
  assign count32   = 32'(count_r);
  assign pick32    = 32'(pick_r);
  assign wrp32     = 32'(wr_ptr_r + CW'(1));
  assign free_sum  = {1'b0, free_r} + {1'b0, e.used};
  assign merge_sum = {1'b0, cur_r.size} + {1'b0, e.size};

  always_comb begin
    fit_policy_nxt = fit_policy_r;
    total_size_nxt = total_size_r;
    count_nxt      = count_r;
    covered_nxt    = covered_r;
    free_nxt       = free_r;
    tail_nxt       = tail_r;
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    owner_nxt      = owner_r;
    size_nxt       = size_r;
    rd_ptr_nxt     = rd_ptr_r;
    rvalid_nxt     = 1'b0;
    didx_nxt       = didx_r;
    wr_ptr_nxt     = wr_ptr_r;
    cur_nxt        = cur_r;
    have_cur_nxt   = have_cur_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    pick_e_nxt     = pick_e_r;
    res_ok_nxt     = res_ok_r;
    res_idx_nxt    = res_idx_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_ok_nxt     = out_ok_r;
    out_idx_nxt    = out_idx_r;
    out_start_nxt  = out_start_r;
    out_free_nxt   = out_free_r;
    out_total_nxt  = out_total_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = rd_ptr_r[AW-1:0];
    mem_we         = 1'b0;
    mem_wr_addr    = didx_r[AW-1:0];
    mem_wr_data    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt      = in_ch.kind;
          owner_nxt     = in_ch.owner_id;
          size_nxt      = in_ch.request_size;
          res_ok_nxt    = 1'b0;
          res_idx_nxt   = 4'd0;
          res_start_nxt = 16'd0;
          rd_ptr_nxt    = '0;
          wr_ptr_nxt    = '0;
          have_cur_nxt  = 1'b0;
          found_nxt     = 1'b0;
          state_nxt     = S_WALK;
          case (in_ch.kind)
            KIND_ADD: begin
              state_nxt = S_DONE;
              if (count_r < CW'(NUM_PARTS) && covered_r < {1'b0, total_size_r}) begin
                mem_we        = 1'b1;
                mem_wr_addr   = count_r[AW-1:0];
                mem_wr_data   = '{owner: 16'd0, used: 16'd0,
                                  size: in_ch.request_size, start: tail_r};
                tail_nxt      = tail_r + in_ch.request_size;
                count_nxt     = count_r + CW'(1);
                covered_nxt   = covered_r + {1'b0, in_ch.request_size};
                res_ok_nxt    = 1'b1;
                res_idx_nxt   = count32[3:0];
                res_start_nxt = tail_r;
              end
            end
            KIND_ALLOC: begin
              if (in_ch.owner_id == 16'd0 || in_ch.request_size > free_r) begin
                state_nxt = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        if (rd_ptr_r < count_r) begin
          mem_rd_en   = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + CW'(1);
          rvalid_nxt  = 1'b1;
          didx_nxt    = rd_ptr_r;
        end else if (!rvalid_r) begin
          state_nxt = S_FIN;
        end
        if (rvalid_r) begin
          case (kind_r)
            KIND_ALLOC: begin
              if (e.owner == 16'd0 && e.size >= size_r) begin
                if (!found_r || (fit_policy_r == FIT_BEST && e.size < pick_e_r.size) ||
                    (fit_policy_r == FIT_WORST && e.size > pick_e_r.size)) begin
                  found_nxt  = 1'b1;
                  pick_nxt   = didx_r;
                  pick_e_nxt = e;
                end
              end
            end
            KIND_FREE: begin
              if (e.owner == owner_r) begin
                mem_we      = 1'b1;
                mem_wr_addr = didx_r[AW-1:0];
                mem_wr_data = '{owner: 16'd0, used: 16'd0, size: e.size, start: e.start};
                free_nxt    = free_sum[16] ? UNITS_MAX : free_sum[15:0];
              end
            end
            KIND_COAL: begin
              // The held entry absorbs free neighbours until one cannot be merged.
              if (!have_cur_r) begin
                cur_nxt      = e;
                have_cur_nxt = 1'b1;
              end else if (cur_r.owner == 16'd0 && e.owner == 16'd0 && !merge_sum[16]) begin
                cur_nxt.size = merge_sum[15:0];
              end else begin
                mem_we      = 1'b1;
                mem_wr_addr = wr_ptr_r[AW-1:0];
                mem_wr_data = cur_r;
                wr_ptr_nxt  = wr_ptr_r + CW'(1);
                cur_nxt     = e;
              end
            end
            default: ;
          endcase
        end
      end

      S_FIN: begin
        state_nxt = S_DONE;
        case (kind_r)
          KIND_ALLOC: begin
            if (found_r) begin
              mem_we        = 1'b1;
              mem_wr_addr   = pick_r[AW-1:0];
              mem_wr_data   = '{owner: owner_r, used: size_r,
                                size: pick_e_r.size, start: pick_e_r.start};
              free_nxt      = free_r - size_r;
              res_ok_nxt    = 1'b1;
              res_idx_nxt   = pick32[3:0];
              res_start_nxt = pick_e_r.start;
            end
          end
          KIND_COAL: begin
            res_ok_nxt = 1'b1;
            if (have_cur_r) begin
              mem_we      = 1'b1;
              mem_wr_addr = wr_ptr_r[AW-1:0];
              mem_wr_data = cur_r;
              count_nxt   = wrp32[CW-1:0];
            end
          end
          default: res_ok_nxt = 1'b1;
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_idx_nxt   = res_idx_r;
          out_start_nxt = res_start_r;
          out_free_nxt  = free_r;
          out_total_nxt = count32[4:0];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Registers must be written only while idle (unchecked); total_size writes reload free_r.
    if (cfg_we) begin
      case (paddr[2])
        REG_FIT_POLICY: fit_policy_nxt = pwdata[1:0];
        REG_TOTAL_SIZE: begin
          total_size_nxt = pwdata[15:0];
          free_nxt       = pwdata[15:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= FIT_FIRST;
      total_size_r <= UNITS_MAX;
      count_r      <= '0;
      covered_r    <= '0;
      free_r       <= UNITS_MAX;
      tail_r       <= '0;
      state_r      <= S_IDLE;
      rvalid_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fit_policy_r <= fit_policy_nxt;
      total_size_r <= total_size_nxt;
      count_r      <= count_nxt;
      covered_r    <= covered_nxt;
      free_r       <= free_nxt;
      tail_r       <= tail_nxt;
      state_r      <= state_nxt;
      rvalid_r     <= rvalid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    kind_r      <= kind_nxt;
    owner_r     <= owner_nxt;
    size_r      <= size_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    didx_r      <= didx_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    cur_r       <= cur_nxt;
    have_cur_r  <= have_cur_nxt;
    found_r     <= found_nxt;
    pick_r      <= pick_nxt;
    pick_e_r    <= pick_e_nxt;
    res_ok_r    <= res_ok_nxt;
    res_idx_r   <= res_idx_nxt;
    res_start_r <= res_start_nxt;
    out_ok_r    <= out_ok_nxt;
    out_idx_r   <= out_idx_nxt;
    out_start_r <= out_start_nxt;
    out_free_r  <= out_free_nxt;
    out_total_r <= out_total_nxt;
  end

  // The table never holds more partitions than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(NUM_PARTS))
    else $error("partition count beyond table depth");

  // A write during the walk never lands on the entry being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("table read and write collide");

  // Returned read data only appears while the walk is running.
  a_rvalid_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> (state_r == S_WALK))
    else $error("read data outside the walk");

  // A new result is only presented after the request has finished.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result presented without a finished request");

endmodule

[rtl/core/pfa_mem.sv]
module pfa_mem
  import pfa_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for the partition fit allocator core.
// A scoreboard class keeps its own copy of the partition table and the two
// registers, predicts one result for every accepted request and compares
// each accepted result with the oldest prediction.
module tb_top;
  import pfa_pkg::*;

  localparam int PARTS   = 16;
  localparam int WD_MAX  = 20000;

  typedef struct packed {
    logic        ok;
    logic [3:0]  idx;
    logic [15:0] start;
    logic [15:0] free;
    logic [4:0]  total;
  } alloc_result_t;

  // Predictor of the allocator together with the queue of pending results.
  class alloc_scoreboard;
    logic [1:0]  policy;
    logic [15:0] total_size;
    logic [15:0] p_start [PARTS];
    logic [15:0] p_size  [PARTS];
    logic [15:0] p_used  [PARTS];
    logic [15:0] p_owner [PARTS];
    int          count;
    int          covered;
    int          free_ctr;
    alloc_result_t pending [$];
    int          errors;

    function new();
      policy = FIT_FIRST; total_size = 16'hFFFF;
      count = 0; covered = 0; free_ctr = 65535; errors = 0;
    endfunction

    function void write_reg(logic addr_sel, logic [15:0] v);
      if (addr_sel == REG_FIT_POLICY) policy = v[1:0];
      else begin
        total_size = v; free_ctr = v;
      end
    endfunction

    // Note one accepted request and queue the result it must cause.
    function void note_request(logic [1:0] kind, logic [15:0] owner, logic [15:0] size);
      alloc_result_t r;
      int pick, s;
      bit found;
      r = '0; r.ok = 1'b1;
      case (kind)
        KIND_ADD: begin
          if (count >= PARTS || covered >= total_size) r.ok = 1'b0;
          else begin
            s = (count > 0) ? ((p_start[count-1] + p_size[count-1]) & 16'hFFFF) : 0;
            p_start[count] = 16'(s); p_size[count] = size;
            p_used[count] = 0; p_owner[count] = 0;
            r.idx = 4'(count); r.start = 16'(s);
            count++; covered += size;
          end
        end
        KIND_ALLOC: begin
          found = 0; pick = 0;
          if (owner != 0 && size <= free_ctr) begin
            for (int i = 0; i < count; i++) begin
              if (p_owner[i] != 0 || p_size[i] < size) continue;
              if (!found) begin
                found = 1; pick = i;
                if (policy != FIT_BEST && policy != FIT_WORST) break;
              end else if (policy == FIT_BEST && p_size[i] < p_size[pick]) begin
                pick = i;
              end else if (policy == FIT_WORST && p_size[i] > p_size[pick]) begin
                pick = i;
              end
            end
          end
          if (!found) r.ok = 1'b0;
          else begin
            free_ctr -= size; p_used[pick] = size; p_owner[pick] = owner;
            r.idx = 4'(pick); r.start = p_start[pick];
          end
        end
        KIND_FREE: begin
          for (int i = 0; i < count; i++) begin
            if (p_owner[i] == owner) begin
              free_ctr += p_used[i];
              if (free_ctr > 65535) free_ctr = 65535;
              p_used[i] = 0; p_owner[i] = 0;
            end
          end
        end
        default: begin
          s = 0;
          while (s + 1 < count) begin
            if (p_owner[s] == 0 && p_owner[s+1] == 0 &&
                (int'(p_size[s]) + int'(p_size[s+1])) <= 65535) begin
              p_size[s] = p_size[s] + p_size[s+1];
              for (int j = s + 1; j + 1 < count; j++) begin
                p_start[j] = p_start[j+1]; p_size[j] = p_size[j+1];
                p_used[j] = p_used[j+1]; p_owner[j] = p_owner[j+1];
              end
              count--;
            end else begin
              s++;
            end
          end
        end
      endcase
      r.free = free_ctr[15:0]; r.total = count[4:0];
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got, longint t);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", t, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ok != e.ok) begin
        $display("%0t: ok expected %0d actual %0d", t, e.ok, got.ok); errors++;
      end
      if (got.idx != e.idx) begin
        $display("%0t: block_index expected %0d actual %0d", t, e.idx, got.idx); errors++;
      end
      if (got.start != e.start) begin
        $display("%0t: block_start expected %0d actual %0d", t, e.start, got.start);
        errors++;
      end
      if (got.free != e.free) begin
        $display("%0t: free_units expected %0d actual %0d", t, e.free, got.free); errors++;
      end
      if (got.total != e.total) begin
        $display("%0t: block_total expected %0d actual %0d", t, e.total, got.total);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pfa_in_if  in_ch();
  pfa_out_if out_ch();

  partition_fit_allocator_core #(.NUM_PARTS(PARTS)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  alloc_scoreboard sb = new();
  int  stall_hold = 0;     // long receiver hold-off requested by the stimulus
  int  idle_cycles = 0;
  logic [15:0] live_owners [$];

  initial begin
    in_ch.valid = 1'b0; in_ch.kind = KIND_ADD;
    in_ch.owner_id = '0; in_ch.request_size = '0;
    out_ch.ready = 1'b0;
  end

  // Gap length: mostly short, now and then long, sometimes none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Results are sampled on the rising edge; ready changes on the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.ok, out_ch.block_index, out_ch.block_start,
                       out_ch.free_units, out_ch.block_total}, $time);
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.kind, in_ch.owner_id, in_ch.request_size);
  end

  // Receiver process: random stalls, plus the long hold-off on request.
  initial begin : receiver
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall_hold) @(negedge clk);
        stall_hold = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no handshake takes place.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One request: optional gap first, then hold valid until accepted. Valid stays
  // high afterwards so that the next request can follow without a gap; whoever
  // stops sending drops it.
  task automatic send_request(logic [1:0] kind, logic [15:0] owner, logic [15:0] size,
                              bit with_gap);
    int g;
    g = with_gap ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.kind <= kind;
    in_ch.owner_id <= owner; in_ch.request_size <= size;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write in two APB phases, done only while the block is idle.
  task automatic reg_write(logic sel, logic [15:0] v);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PARTS + 6) @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {sel, 2'b00}; pwdata <= {16'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(sel, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] pick_owner();
    if (live_owners.size() > 0 && $urandom_range(0, 3) != 0)
      return live_owners[$urandom_range(0, live_owners.size() - 1)];
    return 16'($urandom_range(1, 12));
  endfunction

  // One random request of a well-formed workload, with some noise mixed in.
  task automatic random_request();
    int r;
    logic [15:0] o, s;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      s = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 4000));
      send_request(KIND_ADD, 16'($urandom()), s, 1);
    end else if (r < 65) begin
      o = ($urandom_range(0, 19) == 0) ? 16'h0 : 16'($urandom_range(1, 12));
      if ($urandom_range(0, 19) == 0) o = 16'($urandom());
      s = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4000));
      live_owners.push_back(o);
      send_request(KIND_ALLOC, o, s, 1);
    end else if (r < 88) begin
      o = ($urandom_range(0, 14) == 0) ? 16'h0 : pick_owner();
      send_request(KIND_FREE, o, 16'($urandom()), 1);
    end else begin
      send_request(KIND_COAL, 16'($urandom()), 16'($urandom()), 1);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes of add, allocate rules, owner zero, over-request,
    // no fit, free and coalesce.
    send_request(KIND_ADD, 16'h0, 16'hFFFF, 0);        // covers everything at once
    send_request(KIND_ADD, 16'h0, 16'd10, 0);          // memory covered: rejected
    send_request(KIND_ALLOC, 16'h0, 16'd5, 0);         // owner zero rejected
    send_request(KIND_ALLOC, 16'hFFFF, 16'hFFFF, 0);   // takes the whole block
    send_request(KIND_ALLOC, 16'd3, 16'd1, 0);         // no fit
    send_request(KIND_FREE, 16'hFFFF, 16'h0, 0);
    send_request(KIND_FREE, 16'h0, 16'h0, 0);          // releases nothing
    send_request(KIND_COAL, 16'h0, 16'h0, 0);
    reg_write(REG_TOTAL_SIZE, 16'hFFFF);
    reg_write(REG_FIT_POLICY, 16'(FIT_BEST));
    send_request(KIND_ADD, 16'h0, 16'hFFFF, 0);
    send_request(KIND_ADD, 16'h0, 16'd1, 0);           // reset: table emptied only once
    send_request(KIND_ALLOC, 16'd1, 16'd0, 0);
    send_request(KIND_COAL, 16'h0, 16'h0, 0);          // a single partition: nothing to merge
    send_request(KIND_ALLOC, 16'd2, 16'hFFFF, 0);
    reg_write(REG_FIT_POLICY, 16'(FIT_WORST));
    send_request(KIND_FREE, 16'd1, 16'h0, 0);
    send_request(KIND_ALLOC, 16'd4, 16'd1, 0);
    reg_write(REG_FIT_POLICY, 16'd3);                  // unused code acts as first fit
    send_request(KIND_FREE, 16'd2, 16'h0, 0);
    send_request(KIND_FREE, 16'd4, 16'h0, 0);
    send_request(KIND_ALLOC, 16'd5, 16'd1, 0);
    send_request(KIND_COAL, 16'h0, 16'h0, 0);

    // Random phases; each sets a fit policy and a fresh total size.
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_FIT_POLICY, (ph == 7) ? 16'd3 : 16'(ph % 3));
      reg_write(REG_TOTAL_SIZE, (ph == 0) ? 16'd1 : (ph == 1) ? 16'hFFFF :
                16'($urandom_range(2000, 65535)));
      live_owners.delete();
      if (ph == 3) stall_hold = 300;        // block fills up and stalls its input
      for (int k = 0; k < 92; k++) begin
        if (ph == 3 && k < 20) send_request(KIND_ADD, 16'h0, 16'd7, 0);
        else random_request();
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PARTS + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/pfa_pkg.sv
rtl/core/pfa_if.sv
rtl/core/pfa_mem.sv
rtl/core/partition_fit_allocator_core.sv
tb/sv/tb_top.sv
